/* design/smeu_pkg.sv */
// Package: shared types, constants and opcodes for the stack machine execute unit.
package smeu_pkg;

    localparam int STACK_DEPTH_DEF = 256;
    localparam int NUM_REGS_DEF    = 8;
    localparam int RET_DEPTH_DEF   = 64;

    localparam logic [3:0] OP_START = 4'd0;
    localparam logic [3:0] OP_PUSH  = 4'd1;
    localparam logic [3:0] OP_POP   = 4'd2;
    localparam logic [3:0] OP_PUSHR = 4'd3;
    localparam logic [3:0] OP_POPR  = 4'd4;
    localparam logic [3:0] OP_ADD   = 4'd5;
    localparam logic [3:0] OP_SUB   = 4'd6;
    localparam logic [3:0] OP_MUL   = 4'd7;
    localparam logic [3:0] OP_DIV   = 4'd8;
    localparam logic [3:0] OP_SQRT  = 4'd9;
    localparam logic [3:0] OP_HALT  = 4'd10;
    localparam logic [3:0] OP_CMP   = 4'd11;
    localparam logic [3:0] OP_CALL  = 4'd12;
    localparam logic [3:0] OP_RET   = 4'd13;

    localparam logic [3:0] ST_OK       = 4'd0;
    localparam logic [3:0] ST_START    = 4'd1;
    localparam logic [3:0] ST_STOP     = 4'd2;
    localparam logic [3:0] ST_UNDEF    = 4'd3;
    localparam logic [3:0] ST_POPR_UF  = 4'd4;
    localparam logic [3:0] ST_UNDER    = 4'd5;
    localparam logic [3:0] ST_OVER     = 4'd6;
    localparam logic [3:0] ST_DIV_ZERO = 4'd7;
    localparam logic [3:0] ST_NEG_SQRT = 4'd8;
    localparam logic [3:0] ST_RET_UF   = 4'd9;
    localparam logic [3:0] ST_RET_OF   = 4'd10;

    localparam logic [2:0] CMP_LT = 3'd0;
    localparam logic [2:0] CMP_LE = 3'd1;
    localparam logic [2:0] CMP_GT = 3'd2;
    localparam logic [2:0] CMP_GE = 3'd3;
    localparam logic [2:0] CMP_EQ = 3'd4;
    localparam logic [2:0] CMP_NE = 3'd5;

    typedef struct packed {
        logic [3:0]         req_type;
        logic signed [31:0] immediate;
        logic [2:0]         reg_index;
        logic [2:0]         cmp_kind;
        logic [15:0]        return_address;
    } t_req;

    typedef struct packed {
        logic [3:0]         status;
        logic               jump_taken;
        logic [15:0]        popped_address;
        logic signed [31:0] pushed_value;
    } t_rsp;

    // iterative unit control
    typedef struct packed {
        logic        start;
        logic        is_sqrt;
        logic [31:0] a;  // dividend or radicand
        logic [31:0] b;  // divisor
    } t_iter_cmd;

    typedef struct packed {
        logic        done;
        logic [31:0] res;
    } t_iter_rsp;

endpackage

/* design/smeu_ram.sv */
// Generic single-port-write RAM with registered read.
module smeu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

/* design/smeu_iter.sv */
// Iterative bit-serial unsigned divider and floor square root.
module smeu_iter
    import smeu_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_iter_cmd i_cmd,
    output t_iter_rsp o_rsp
);
    logic        r_busy, n_busy;
    logic        r_sqrt;
    logic [5:0]  r_cnt;
    logic [31:0] r_q, r_b;
    logic [33:0] r_rem;
    logic [31:0] r_src;
    logic [33:0] w_trial, w_sh;

    // divide: shift one dividend bit per cycle; sqrt: two radicand bits per cycle
    always_comb begin
        if (r_sqrt) begin
            w_sh    = {r_rem[31:0], r_src[31:30]};
            w_trial = w_sh - {r_q, 2'b01};
        end else begin
            w_sh    = {r_rem[32:0], r_src[31]};
            w_trial = w_sh - {2'b00, r_b};
        end
        n_busy = r_busy;
        if (i_cmd.start) n_busy = 1'b1;
        else if (r_busy && r_cnt == 6'd0) n_busy = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
        if (i_cmd.start) begin
            r_sqrt <= i_cmd.is_sqrt;
            r_src  <= i_cmd.a;
            r_b    <= i_cmd.b;
            r_q    <= '0;
            r_rem  <= '0;
            r_cnt  <= i_cmd.is_sqrt ? 6'd15 : 6'd31;
        end else if (r_busy) begin
            r_src <= r_sqrt ? {r_src[29:0], 2'b00} : {r_src[30:0], 1'b0};
            r_cnt <= r_cnt - 6'd1;
            if (!w_trial[33]) begin
                r_rem <= w_trial;
                r_q   <= {r_q[30:0], 1'b1};
            end else begin
                r_rem <= w_sh;
                r_q   <= {r_q[30:0], 1'b0};
            end
        end
    end

    assign o_rsp.done = r_busy && r_cnt == 6'd0;
    assign o_rsp.res  = w_trial[33] ? {r_q[30:0], 1'b0} : {r_q[30:0], 1'b1};
endmodule

/* design/stack_machine_execute_unit_top.sv */
// Top level: sequencer, stacks, register file and result register of the execute unit.
//
//  channel | signals                        | direction
//  --------+--------------------------------+----------
//  request | i_valid, o_ready, i_req        | in
//  result  | o_valid, i_ready, o_rsp        | out
//
// Simple ops go through accept, two stack reads, execute and result; mul adds S_MUL after execute.
// Div and sqrt wait in S_ITER for the bit-serial iterative unit.
// Synchronous active-low reset clears pointers and register valid bits; no clearing pass.
// A new transaction is taken only after the previous result has left the output register.
module stack_machine_execute_unit_top
    import smeu_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    parameter int NUM_REGS    = NUM_REGS_DEF,
    parameter int RET_DEPTH   = RET_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_req i_req,
    output logic o_valid,
    input  logic i_ready,
    output t_rsp o_rsp
);
    localparam int DAW = $clog2(STACK_DEPTH);
    localparam int DPW = $clog2(STACK_DEPTH + 1);
    localparam int RAW = $clog2(RET_DEPTH);
    localparam int RPW = $clog2(RET_DEPTH + 1);
    localparam int RIW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_RD1   = 7'b0000010,
        S_RD2   = 7'b0000100,
        S_EXEC  = 7'b0001000,
        S_MUL   = 7'b0010000,
        S_ITER  = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    t_req   r_req;
    t_rsp   r_rsp;
    logic [DPW-1:0] r_dp;
    logic [RPW-1:0] r_rp;
    logic [NUM_REGS-1:0] r_rvalid;
    logic [31:0] r_regs [NUM_REGS];
    logic [31:0] r_top, r_nxt;
    logic [63:0] r_prod;
    logic        r_neg;

    // data stack RAM
    logic           ds_we;
    logic [DAW-1:0] ds_waddr, ds_raddr;
    logic [31:0]    ds_wdata, ds_rdata;
    smeu_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_ds (
        .i_clk(i_clk), .i_we(ds_we), .i_waddr(ds_waddr), .i_wdata(ds_wdata),
        .i_raddr(ds_raddr), .o_rdata(ds_rdata)
    );

    logic           rs_we;
    logic [15:0]    rs_rdata;
    smeu_ram #(.WIDTH(16), .DEPTH(RET_DEPTH)) u_rs (
        .i_clk(i_clk), .i_we(rs_we), .i_waddr(r_rp[RAW-1:0]),
        .i_wdata(r_req.return_address), .i_raddr(RAW'(r_rp - RPW'(1))),
        .o_rdata(rs_rdata)
    );

    t_iter_cmd it_cmd;
    t_iter_rsp it_rsp;
    smeu_iter u_iter (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(it_cmd), .o_rsp(it_rsp));

    logic        reg_ok;
    logic [RIW-1:0] reg_sel;
    logic        cmp_res;
    logic signed [31:0] st, sn;
    logic [31:0] abs_top, abs_nxt;

    assign st = r_top;
    assign sn = r_nxt;
    assign abs_top = r_top[31] ? 32'(-r_top) : r_top;
    assign abs_nxt = r_nxt[31] ? 32'(-r_nxt) : r_nxt;
    assign reg_ok  = (32'(r_req.reg_index) < NUM_REGS);
    assign reg_sel = RIW'(r_req.reg_index);

    always_comb begin
        case (r_req.cmp_kind)
            CMP_LT:  cmp_res = st < sn;
            CMP_LE:  cmp_res = st <= sn;
            CMP_GT:  cmp_res = st > sn;
            CMP_GE:  cmp_res = st >= sn;
            CMP_EQ:  cmp_res = st == sn;
            CMP_NE:  cmp_res = st != sn;
            default: cmp_res = 1'b0;
        endcase
    end

    // read top in S_IDLE->RD1 address, next in RD1
    always_comb begin
        ds_raddr = DAW'(r_dp - DPW'(1));
        if (r_state == S_RD1) ds_raddr = DAW'(r_dp - DPW'(2));
    end

    logic [DPW-1:0] n_dp;
    logic [RPW-1:0] n_rp;
    t_rsp n_rsp;
    logic n_push;
    logic [31:0] n_pval;
    logic [NUM_REGS-1:0] n_rvalid;
    logic reg_we;

    always_comb begin
        n_state  = r_state;
        n_dp     = r_dp;
        n_rp     = r_rp;
        n_rsp    = r_rsp;
        n_push   = 1'b0;
        n_pval   = '0;
        n_rvalid = r_rvalid;
        reg_we   = 1'b0;
        rs_we    = 1'b0;
        it_cmd   = '0;
        case (r_state)
            S_IDLE: if (i_valid) n_state = S_RD1;
            S_RD1:  n_state = S_RD2;
            S_RD2:  n_state = S_EXEC;
            S_EXEC: begin
                n_rsp   = '0;
                n_state = S_OUT;
                case (r_req.req_type)
                    OP_START: n_rsp.status = ST_START;
                    OP_HALT:  n_rsp.status = ST_STOP;
                    OP_PUSH: begin
                        if (32'(r_dp) >= STACK_DEPTH) n_rsp.status = ST_OVER;
                        else begin
                            n_push = 1'b1;
                            n_pval = r_req.immediate;
                        end
                    end
                    OP_POP: begin
                        if (r_dp == '0) n_rsp.status = ST_UNDER;
                        else n_dp = r_dp - DPW'(1);
                    end
                    OP_PUSHR: begin
                        if (!reg_ok || !r_rvalid[reg_sel])
                            n_rsp.status = ST_UNDEF;
                        else if (32'(r_dp) >= STACK_DEPTH) n_rsp.status = ST_OVER;
                        else begin
                            n_push = 1'b1;
                            n_pval = r_regs[reg_sel];
                        end
                    end
                    OP_POPR: begin
                        if (!reg_ok) n_rsp.status = ST_UNDEF;
                        else if (r_dp == '0) n_rsp.status = ST_POPR_UF;
                        else begin
                            n_dp   = r_dp - DPW'(1);
                            reg_we = 1'b1;
                            n_rvalid[reg_sel] = 1'b1;
                        end
                    end
                    OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_CMP: begin
                        if (r_dp < DPW'(2)) n_rsp.status = ST_UNDER;
                        else if (r_req.req_type == OP_CMP) begin
                            n_rsp.jump_taken = cmp_res;
                            n_dp = r_dp - DPW'(2);
                        end else if (r_req.req_type == OP_ADD) begin
                            n_dp = r_dp - DPW'(2);
                            n_push = 1'b1;
                            n_pval = r_nxt + r_top;
                        end else if (r_req.req_type == OP_SUB) begin
                            n_dp = r_dp - DPW'(2);
                            n_push = 1'b1;
                            n_pval = r_nxt - r_top;
                        end else if (r_req.req_type == OP_MUL) begin
                            n_state = S_MUL;
                        end else if (r_top == '0) begin
                            n_rsp.status = ST_DIV_ZERO;
                        end else begin
                            it_cmd.start = 1'b1;
                            it_cmd.a     = abs_nxt;
                            it_cmd.b     = abs_top;
                            n_state      = S_ITER;
                        end
                    end
                    OP_SQRT: begin
                        if (r_dp == '0) n_rsp.status = ST_UNDER;
                        else if (r_top[31]) n_rsp.status = ST_NEG_SQRT;
                        else begin
                            it_cmd.start   = 1'b1;
                            it_cmd.is_sqrt = 1'b1;
                            it_cmd.a       = r_top;
                            n_state        = S_ITER;
                        end
                    end
                    OP_CALL: begin
                        if (32'(r_rp) >= RET_DEPTH) n_rsp.status = ST_RET_OF;
                        else begin
                            rs_we = 1'b1;
                            n_rp  = r_rp + RPW'(1);
                        end
                    end
                    OP_RET: begin
                        if (r_rp == '0) n_rsp.status = ST_RET_UF;
                        else begin
                            n_rp = r_rp - RPW'(1);
                            n_rsp.popped_address = rs_rdata;
                        end
                    end
                    default: ;
                endcase
                n_rsp.pushed_value = n_pval;
            end
            S_MUL: begin
                n_dp   = r_dp - DPW'(2);
                n_push = 1'b1;
                n_pval = r_prod[31:0];
                n_rsp.pushed_value = n_pval;
                n_state = S_OUT;
            end
            S_ITER: begin
                if (it_rsp.done) begin
                    n_dp   = (r_req.req_type == OP_SQRT) ? r_dp - DPW'(1) : r_dp - DPW'(2);
                    n_push = 1'b1;
                    n_pval = r_neg ? 32'(-it_rsp.res) : it_rsp.res;
                    n_rsp.pushed_value = n_pval;
                    n_state = S_OUT;
                end
            end
            S_OUT: if (i_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    assign ds_we    = n_push;
    assign ds_waddr = n_dp[DAW-1:0];
    assign ds_wdata = n_pval;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_dp     <= '0;
            r_rp     <= '0;
            r_rvalid <= '0;
        end else begin
            r_state  <= n_state;
            r_dp     <= n_push ? n_dp + DPW'(1) : n_dp;
            r_rp     <= n_rp;
            r_rvalid <= n_rvalid;
        end
        if (r_state == S_IDLE && i_valid) r_req <= i_req;
        if (r_state == S_RD1) r_top <= ds_rdata;
        if (r_state == S_RD2) r_nxt <= ds_rdata;
        if (r_state == S_EXEC) begin
            r_prod <= 64'(r_nxt) * 64'(r_top);
            r_neg  <= (r_req.req_type == OP_DIV) && (r_top[31] ^ r_nxt[31]);
        end
        if (reg_we) r_regs[reg_sel] <= r_top;
        r_rsp <= n_rsp;
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_OUT);
    assign o_rsp   = r_rsp;
endmodule

/* tb/sv/testbench.sv */
// Testbench for the stack machine execute unit: directed and random instruction streams against a predictor.
module testbench;
    import smeu_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    t_req i_req = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    t_rsp o_rsp;

    stack_machine_execute_unit_top uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_req(i_req),
        .o_valid(o_valid), .i_ready(i_ready), .o_rsp(o_rsp)
    );

    always #5 i_clk = ~i_clk;

    // predictor state
    logic [31:0] dstack [STACK_DEPTH_DEF];
    int unsigned dptr;
    logic [31:0] regs [NUM_REGS_DEF];
    logic [NUM_REGS_DEF-1:0] reg_ok;
    logic [15:0] rstack [RET_DEPTH_DEF];
    int unsigned rptr;

    t_req pending_reqs[$];
    t_rsp expected_rsps[$];
    int mismatches = 0;
    int stim_done = 0;
    int quiet_tail = 0;      // no idling near the end
    int hold_rx = 0;         // long receiver hold-off request
    int pause_tx = 0;        // sender pauses until drained
    int tx_gap = 0, rx_gap = 0;

    function automatic logic [31:0] isqrt(logic [31:0] v);
        logic [31:0] r, b;
        r = 0;
        b = 32'h4000_0000;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic t_rsp execute(t_req q);
        t_rsp r;
        logic signed [31:0] a, b;
        logic push;
        r = '0;
        push = 1'b0;
        case (q.req_type)
            OP_START: r.status = ST_START;
            OP_HALT: r.status = ST_STOP;
            OP_PUSH: begin
                if (dptr >= STACK_DEPTH_DEF) r.status = ST_OVER;
                else begin r.pushed_value = q.immediate; push = 1'b1; end
            end
            OP_POP: begin
                if (dptr == 0) r.status = ST_UNDER;
                else dptr--;
            end
            OP_PUSHR: begin
                if (q.reg_index >= NUM_REGS_DEF || !reg_ok[q.reg_index]) r.status = ST_UNDEF;
                else if (dptr >= STACK_DEPTH_DEF) r.status = ST_OVER;
                else begin r.pushed_value = regs[q.reg_index]; push = 1'b1; end
            end
            OP_POPR: begin
                if (q.reg_index >= NUM_REGS_DEF) r.status = ST_UNDEF;
                else if (dptr == 0) r.status = ST_POPR_UF;
                else begin
                    dptr--;
                    regs[q.reg_index] = dstack[dptr];
                    reg_ok[q.reg_index] = 1'b1;
                end
            end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_CMP: begin
                if (dptr < 2) r.status = ST_UNDER;
                else begin
                    a = dstack[dptr-1];
                    b = dstack[dptr-2];
                    if (q.req_type == OP_CMP) begin
                        case (q.cmp_kind)
                            CMP_LT: r.jump_taken = a < b;
                            CMP_LE: r.jump_taken = a <= b;
                            CMP_GT: r.jump_taken = a > b;
                            CMP_GE: r.jump_taken = a >= b;
                            CMP_EQ: r.jump_taken = a == b;
                            CMP_NE: r.jump_taken = a != b;
                            default: r.jump_taken = 1'b0;
                        endcase
                        dptr -= 2;
                    end else if (q.req_type == OP_DIV && a == 0) begin
                        r.status = ST_DIV_ZERO;
                    end else begin
                        case (q.req_type)
                            OP_ADD: r.pushed_value = b + a;
                            OP_SUB: r.pushed_value = b - a;
                            OP_MUL: r.pushed_value = b * a;
                            default: begin
                                if (b == 32'sh8000_0000 && a == -32'sd1)
                                    r.pushed_value = 32'sh8000_0000;
                                else
                                    r.pushed_value = b / a;
                            end
                        endcase
                        dptr -= 2;
                        push = 1'b1;
                    end
                end
            end
            OP_SQRT: begin
                if (dptr == 0) r.status = ST_UNDER;
                else if (dstack[dptr-1][31]) r.status = ST_NEG_SQRT;
                else begin
                    dptr--;
                    r.pushed_value = isqrt(dstack[dptr]);
                    push = 1'b1;
                end
            end
            OP_CALL: begin
                if (rptr >= RET_DEPTH_DEF) r.status = ST_RET_OF;
                else begin rstack[rptr] = q.return_address; rptr++; end
            end
            OP_RET: begin
                if (rptr == 0) r.status = ST_RET_UF;
                else begin rptr--; r.popped_address = rstack[rptr]; end
            end
            default: ;
        endcase
        if (push) begin
            dstack[dptr] = r.pushed_value;
            dptr++;
        end
        return r;
    endfunction

    function automatic t_req make_op(logic [3:0] op, logic signed [31:0] imm);
        t_req q;
        q.req_type = op;
        q.immediate = imm;
        q.reg_index = 3'($urandom_range(0, 7));
        q.cmp_kind = 3'($urandom_range(0, 7));
        q.return_address = 16'($urandom);
        return q;
    endfunction

    function automatic logic signed [31:0] rand_value();
        case ($urandom_range(0, 5))
            0: return 32'($urandom_range(0, 20));
            1: return -32'sd1 * $signed(32'($urandom_range(0, 20)));
            2: return 32'sh8000_0000;
            3: return 32'sh7fff_ffff;
            default: return $signed(32'($urandom));
        endcase
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_valid || o_ready) begin
            if (i_valid && o_ready) pending_reqs.pop_front();
            if (tx_gap > 0) begin
                tx_gap <= tx_gap - 1;
                i_valid <= 1'b0;
            end else if (pause_tx && (expected_rsps.size() != 0 || (i_valid && o_ready))) begin
                i_valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
                if (!quiet_tail && !hold_rx && $urandom_range(0, 9) == 0) begin
                    tx_gap <= $urandom_range(1, 14);
                    i_valid <= 1'b0;
                end else begin
                    i_valid <= 1'b1;
                    i_req <= pending_reqs[0];
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // predict on acceptance
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_ready)
            expected_rsps.push_back(execute(i_req));
    end

    // receiver idling and long hold-off
    int hold_count = 0;
    always @(posedge i_clk) begin
        if (hold_rx && hold_count < 300) begin
            hold_count <= hold_count + 1;
            i_ready <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap <= rx_gap - 1;
            i_ready <= 1'b0;
        end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
            rx_gap <= $urandom_range(1, 14);
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_rsps.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", o_rsp);
            end else begin
                want = expected_rsps.pop_front();
                if (o_rsp !== want) begin
                    mismatches++;
                    if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, o_rsp);
                end
            end
        end
    end

    initial begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        int k, n;
        dptr = 0; rptr = 0; reg_ok = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // directed: failure paths (not negative sqrt or POPR underflow) and extremes
        pending_reqs.push_back(make_op(OP_START, 0));
        pending_reqs.push_back(make_op(OP_POP, 0));
        pending_reqs.push_back(make_op(OP_SQRT, 0));
        pending_reqs.push_back(make_op(OP_ADD, 0));
        pending_reqs.push_back(make_op(OP_RET, 0));
        pending_reqs.push_back(make_op(4'd14, 0));
        pending_reqs.push_back(make_op(4'd15, -1));
        pending_reqs.push_back(make_op(OP_PUSH, 32'sh8000_0000));
        pending_reqs.push_back(make_op(OP_PUSH, -32'sd1));
        pending_reqs.push_back(make_op(OP_DIV, 0));
        pending_reqs.push_back(make_op(OP_PUSH, 32'sh7fff_ffff));
        pending_reqs.push_back(make_op(OP_SQRT, 0));
        pending_reqs.push_back(make_op(OP_PUSH, 0));
        pending_reqs.push_back(make_op(OP_DIV, 0));
        pending_reqs.push_back(make_op(OP_SQRT, 0));
        pending_reqs.push_back(make_op(OP_MUL, 0));
        pending_reqs.push_back(make_op(OP_POPR, 0));
        pending_reqs.push_back(make_op(OP_PUSHR, 0));
        pending_reqs.push_back(make_op(OP_CALL, 0));
        pending_reqs.push_back(make_op(OP_RET, 0));
        pending_reqs.push_back(make_op(OP_HALT, 0));
        // fill the return stack past its top, then drain past empty
        repeat (65) pending_reqs.push_back(make_op(OP_CALL, 0));
        repeat (65) pending_reqs.push_back(make_op(OP_RET, 0));
        // fill the data stack past its top
        repeat (258) pending_reqs.push_back(make_op(OP_PUSH, rand_value()));
        pending_reqs.push_back(make_op(OP_PUSHR, 0));
        // long receiver hold-off while items keep coming
        hold_rx = 1;
        wait (pending_reqs.size() == 0);
        hold_rx = 0;
        repeat (20) pending_reqs.push_back(make_op(OP_POP, 0));
        wait (pending_reqs.size() == 0);
        pause_tx = 1;
        wait (expected_rsps.size() == 0);
        pause_tx = 0;
        // random: mostly well-formed operand sequences
        for (k = 0; k < 12; k++) begin
            n = $urandom_range(0, 9);
            if (n < 6) begin
                pending_reqs.push_back(make_op(OP_PUSH, rand_value()));
                pending_reqs.push_back(make_op(OP_PUSH, rand_value()));
                pending_reqs.push_back(make_op(4'($urandom_range(OP_ADD, OP_CMP)), 0));
            end else begin
                pending_reqs.push_back(make_op(4'($urandom_range(0, 15)), rand_value()));
            end
            if (k == 8) begin
                wait (pending_reqs.size() == 0);
                quiet_tail = 1;
            end
            if (pending_reqs.size() > 40) wait (pending_reqs.size() < 10);
        end
        wait (pending_reqs.size() == 0 && !i_valid);
        wait (expected_rsps.size() == 0);
        repeat (60) @(posedge i_clk);
        if (mismatches == 0 && expected_rsps.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

/* stack_machine_execute_unit_top.f */
design/smeu_pkg.sv
design/smeu_ram.sv
design/smeu_iter.sv
design/stack_machine_execute_unit_top.sv
tb/sv/testbench.sv
